// ===== hw/rtl/lphm_pkg.sv =====
// shared types and constants for the linear probe hash map
`default_nettype none

package lphm_pkg;

  localparam int KEY_W = 64;
  localparam int VAL_W = 64;
  localparam int CNT_W = 7;

  localparam logic [CNT_W-1:0] LOAD_LIMIT_RESET = 7'd51;

  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_GET    = 2'd1,
    OP_REMOVE = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    MARK_EMPTY   = 2'd0,
    MARK_USED    = 2'd1,
    MARK_DELETED = 2'd2
  } mark_t;

  typedef enum logic [2:0] {
    STAT_INSERTED    = 3'd0,
    STAT_OVERWRITTEN = 3'd1,
    STAT_FOUND       = 3'd2,
    STAT_REMOVED     = 3'd3,
    STAT_NOT_FOUND   = 3'd4,
    STAT_FULL        = 3'd5
  } status_t;

  typedef struct packed {
    mark_t             mark;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } slot_t;

  typedef struct packed {
    logic is_empty;
    logic is_hit;
    logic is_free;
  } slot_check_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lphm_slot_check.sv =====
// classification of one slot read from the table against the searched key
`default_nettype none

module lphm_slot_check
  import lphm_pkg::*;
(
  input  mark_t             slot_mark,
  input  logic [KEY_W-1:0]  slot_key,
  input  logic [KEY_W-1:0]  item_key,
  output slot_check_t       result
);

  always_comb begin
    result.is_empty = (slot_mark == MARK_EMPTY);
    result.is_hit   = (slot_mark == MARK_USED) && (slot_key == item_key);
    // empty or deleted slots can take a new key
    result.is_free  = (slot_mark != MARK_USED);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/linear_probe_hash_map_core.sv =====
// top level of the linear probe hash map: slot memory, probe sequencer, result register
// Key-value table of CAPACITY slots (a power of two) with open addressing and
// linear probing. Each item is a set, get or remove of a 64-bit key; its home
// slot is the low bits of key[63:32] xor key[31:0]. All slots sit in one
// synchronous memory with a single read port, and the sequencer walks the
// chain one slot per cycle; a walk visits 1 to CAPACITY slots, up to a
// match, an empty slot or a full lap. After reset, and after a remove that
// takes the table back to no live entries, a clearing pass marks every slot
// empty; in_ready stays low during it, while cfg writes are taken as ever.
// The result of an item sits in an output register, so the next item is
// accepted while it waits; a finished walk holds only if that register is
// still full.
`default_nettype none

module linear_probe_hash_map_core
  import lphm_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  // item input
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_opcode,
  input  logic [KEY_W-1:0]  in_key,
  input  logic [VAL_W-1:0]  in_value,
  // result output
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_status,
  output logic [VAL_W-1:0]  out_read_value,
  output logic [CNT_W-1:0]  out_entry_count,
  // load limit register
  input  logic              cfg_wr_en,
  input  logic [CNT_W-1:0]  cfg_wr_data
);

  localparam int IDX_W = $clog2(CAPACITY);
  // live count wide enough for every slot; the result carries its low bits
  localparam int LIVE_W = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_PROBE = 3'b100
  } state_t;

  // control state
  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  clr_idx_r, clr_idx_nxt;
  logic [IDX_W-1:0]  probe_idx_r, probe_idx_nxt;
  logic [IDX_W-1:0]  visit_r, visit_nxt;
  logic              free_found_r, free_found_nxt;
  logic [IDX_W-1:0]  free_idx_r, free_idx_nxt;
  logic [LIVE_W-1:0] live_r, live_nxt;
  logic [CNT_W-1:0]  limit_r;
  logic              out_valid_r, out_valid_nxt;

  // item payload held for the walk
  opcode_t           op_r, op_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;

  // result payload
  status_t           out_status_r, out_status_nxt;
  logic [VAL_W-1:0]  out_rv_r, out_rv_nxt;
  logic [CNT_W-1:0]  out_cnt_r, out_cnt_nxt;

  // slot memory and its ports
  slot_t             slot_mem [CAPACITY];
  slot_t             rd_data_r;
  logic              mem_rd_en;
  logic [IDX_W-1:0]  mem_rd_addr;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wr_addr;
  slot_t             mem_wr_data;

  slot_check_t       chk;
  logic [IDX_W-1:0]  home_idx;
  logic              last_visit;
  logic              terminal;
  logic              out_free;
  logic              free_now;
  logic [IDX_W-1:0]  free_at;
  logic [LIVE_W-1:0] live_dec;

  lphm_slot_check u_check (
    .slot_mark (rd_data_r.mark),
    .slot_key  (rd_data_r.key),
    .item_key  (key_r),
    .result    (chk)
  );

  // home slot: xor fold of the key halves, low bits only
  assign home_idx   = in_key[IDX_W-1:0] ^ in_key[32 +: IDX_W];

  // the slot in rd_data_r ends the walk on empty, match or a full lap
  assign last_visit = (visit_r == IDX_W'(CAPACITY - 1));
  assign terminal   = chk.is_empty || chk.is_hit || last_visit;
  assign out_free   = !out_valid_r || out_ready;

  // first empty or deleted slot on the chain, including the one in hand
  assign free_now   = free_found_r || chk.is_free;
  assign free_at    = free_found_r ? free_idx_r : probe_idx_r;
  assign live_dec   = (live_r != '0) ? (live_r - LIVE_W'(1)) : live_r;

  assign in_ready   = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    probe_idx_nxt  = probe_idx_r;
    visit_nxt      = visit_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    live_nxt       = live_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_rv_nxt     = out_rv_r;
    out_cnt_nxt    = out_cnt_r;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = probe_idx_r;
    mem_we         = 1'b0;
    mem_wr_addr    = probe_idx_r;
    mem_wr_data    = rd_data_r;

    case (state_r)
      S_CLEAR: begin
        // one slot a cycle back to empty
        mem_we      = 1'b1;
        mem_wr_addr = clr_idx_r;
        mem_wr_data = '{mark: MARK_EMPTY, key: '0, value: '0};
        clr_idx_nxt = clr_idx_r + IDX_W'(1);
        if (clr_idx_r == IDX_W'(CAPACITY - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = opcode_t'(in_opcode);
          key_nxt        = in_key;
          val_nxt        = in_value;
          mem_rd_en      = 1'b1;
          mem_rd_addr    = home_idx;
          probe_idx_nxt  = home_idx;
          visit_nxt      = '0;
          free_found_nxt = 1'b0;
          state_nxt      = S_PROBE;
        end
      end

      S_PROBE: begin
        if (!terminal) begin
          // step to the next slot, wrapping at the end of the table
          if (chk.is_free && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = probe_idx_r;
          end
          probe_idx_nxt = probe_idx_r + IDX_W'(1);
          visit_nxt     = visit_r + IDX_W'(1);
          mem_rd_en     = 1'b1;
          mem_rd_addr   = probe_idx_r + IDX_W'(1);
        end else if (out_free) begin
          // walk done: update the table and post the result
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_NOT_FOUND;
          out_rv_nxt     = '0;
          state_nxt      = S_IDLE;
          case (op_r)
            OP_SET: begin
              if (chk.is_hit) begin
                // equal key: overwrite in place, even past a deleted slot
                mem_we         = 1'b1;
                mem_wr_addr    = probe_idx_r;
                mem_wr_data    = '{mark: MARK_USED, key: key_r, value: val_r};
                out_status_nxt = STAT_OVERWRITTEN;
              end else if ((live_r >= LIVE_W'(limit_r)) || !free_now) begin
                out_status_nxt = STAT_FULL;
              end else begin
                mem_we         = 1'b1;
                mem_wr_addr    = free_at;
                mem_wr_data    = '{mark: MARK_USED, key: key_r, value: val_r};
                live_nxt       = live_r + LIVE_W'(1);
                out_status_nxt = STAT_INSERTED;
              end
            end
            OP_GET: begin
              if (chk.is_hit) begin
                out_status_nxt = STAT_FOUND;
                out_rv_nxt     = rd_data_r.value;
              end
            end
            OP_REMOVE: begin
              if (chk.is_hit) begin
                mem_we         = 1'b1;
                mem_wr_addr    = probe_idx_r;
                mem_wr_data    = '{mark: MARK_DELETED, key: rd_data_r.key,
                                   value: rd_data_r.value};
                live_nxt       = live_dec;
                out_status_nxt = STAT_REMOVED;
                out_rv_nxt     = rd_data_r.value;
                // last live entry gone: wipe every mark
                if (live_dec == '0) begin
                  clr_idx_nxt = '0;
                  state_nxt   = S_CLEAR;
                end
              end
            end
            default: begin
              // unknown opcode: not found, nothing changes
              out_status_nxt = STAT_NOT_FOUND;
            end
          endcase
          out_cnt_nxt = live_nxt[CNT_W-1:0];
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_idx_r    <= '0;
      probe_idx_r  <= '0;
      visit_r      <= '0;
      free_found_r <= 1'b0;
      free_idx_r   <= '0;
      live_r       <= '0;
      limit_r      <= LOAD_LIMIT_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_idx_r    <= clr_idx_nxt;
      probe_idx_r  <= probe_idx_nxt;
      visit_r      <= visit_nxt;
      free_found_r <= free_found_nxt;
      free_idx_r   <= free_idx_nxt;
      live_r       <= live_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    out_status_r <= out_status_nxt;
    out_rv_r     <= out_rv_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_wr_addr] <= mem_wr_data;
    end
    if (mem_rd_en) begin
      rd_data_r <= slot_mem[mem_rd_addr];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = out_rv_r;
  assign out_entry_count = out_cnt_r;

endmodule

`default_nettype wire
